@@ hw/rtl/tpd_pkg.sv @@
// Shared constants and types for the touch packet decoder.
`timescale 1ns / 1ps
`default_nettype none
package tpd_pkg;

  localparam logic [7:0] LEAD_BYTE    = 8'h55;
  localparam logic [7:0] TYPE_TOUCH   = 8'h54;
  localparam logic [7:0] CODE_TOUCH   = 8'h01;
  localparam logic [7:0] CODE_UNTOUCH = 8'h04;

  localparam logic [3:0] LAST_IDX = 4'd9;

  localparam logic signed [15:0] OFFSCREEN = 16'sd4000;

  localparam logic signed [31:0] GAIN_X_RST   = -32'sd16033;
  localparam logic signed [15:0] OFFSET_X_RST = -16'sd3670;
  localparam logic signed [31:0] GAIN_Y_RST   = 32'sd12935;
  localparam logic signed [15:0] OFFSET_Y_RST = -16'sd500;
  localparam logic [14:0]        SNAP_RST     = 15'd30;

  typedef enum logic [2:0] {
    REG_GAIN_X   = 3'd0,
    REG_OFFSET_X = 3'd1,
    REG_GAIN_Y   = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_BYPASS   = 3'd4,
    REG_SNAP     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_DOWN   = 2'd0,
    EV_UP     = 2'd1,
    EV_MOTION = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic vld;
    logic touch;
  } stg_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/touch_packet_decoder.sv @@
// Top level of the touch packet decoder: config registers and pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one serial byte per cycle, hunts for the 'U' lead byte and collects
// 10-byte frames. A touch frame ('T') with code 1 gives a button-down event;
// code 4 gives button-up (each axis snapped to the touch position when within
// snap_distance) followed by a motion event at 4000,4000. Events pass from the
// closing byte of their frame through the frame, offset add, multiply and
// truncate/saturate registers and the snap logic to the output register.
// Only the closing byte of a frame can wait: it is held while earlier events
// are in the frame register, the scaling pipeline or the output register.
module touch_packet_decoder
  import tpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_event_kind,
  output logic signed [15:0]      out_pos_x,
  output logic signed [15:0]      out_pos_y,
  output logic                    out_button,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic signed [31:0] gain_x_r, gain_y_r;
  logic signed [15:0] offset_x_r, offset_y_r;
  logic               bypass_r;
  logic [14:0]        snap_r;

  stg_ctl_t           frm_ctl, scl_ctl;
  logic signed [15:0] raw_x, raw_y, scl_x, scl_y;
  logic               scl_busy, evt_busy, busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_r   <= GAIN_X_RST;
      offset_x_r <= OFFSET_X_RST;
      gain_y_r   <= GAIN_Y_RST;
      offset_y_r <= OFFSET_Y_RST;
      bypass_r   <= 1'b0;
      snap_r     <= SNAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_X:   gain_x_r   <= $signed(cfg_data);
        REG_OFFSET_X: offset_x_r <= $signed(cfg_data[15:0]);
        REG_GAIN_Y:   gain_y_r   <= $signed(cfg_data);
        REG_OFFSET_Y: offset_y_r <= $signed(cfg_data[15:0]);
        REG_BYPASS:   bypass_r   <= cfg_data[0];
        REG_SNAP:     snap_r     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign busy = frm_ctl.vld | scl_busy | evt_busy;

  tpd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .busy       (busy),
    .frm_ctl    (frm_ctl),
    .raw_x      (raw_x),
    .raw_y      (raw_y)
  );

  tpd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (frm_ctl),
    .raw_x    (raw_x),
    .raw_y    (raw_y),
    .gain_x   (gain_x_r),
    .offset_x (offset_x_r),
    .gain_y   (gain_y_r),
    .offset_y (offset_y_r),
    .bypass   (bypass_r),
    .ctl_out  (scl_ctl),
    .pos_x    (scl_x),
    .pos_y    (scl_y),
    .busy     (scl_busy)
  );

  tpd_event u_event (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl_in         (scl_ctl),
    .pos_x          (scl_x),
    .pos_y          (scl_y),
    .snap_distance  (snap_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_button     (out_button),
    .out_last       (out_last),
    .busy           (evt_busy)
  );

`ifndef SYNTHESIS
  a_motion_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind == EV_MOTION)) |->
      (out_last && !out_button && (out_pos_x == OFFSCREEN) && (out_pos_y == OFFSCREEN)))
    else $error("motion event malformed");

  a_not_last_is_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_event_kind == EV_UP))
    else $error("non-final result is not button up");

  a_up_then_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_event_kind == EV_MOTION)))
    else $error("button up not followed by motion");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    scl_ctl.vld |-> !evt_busy)
    else $error("new event while output still occupied");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/tpd_frame.sv @@
// Byte framing: lead byte hunt, frame byte store, frame complete strobe.
`timescale 1ns / 1ps
`default_nettype none
module tpd_frame
  import tpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               busy,
  output stg_ctl_t                frm_ctl,
  output logic signed [15:0]      raw_x,
  output logic signed [15:0]      raw_y
);

  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] fb_r [1:6];
  stg_ctl_t   ctl_r, ctl_nxt;
  logic       acc;

  // hold off the closing byte while an earlier frame is still in flight
  assign in_ready = !((cnt_r == LAST_IDX) && busy);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cnt_nxt       = cnt_r;
    ctl_nxt.vld   = 1'b0;
    ctl_nxt.touch = (fb_r[2] == CODE_TOUCH);
    if (acc) begin
      if (cnt_r == 4'd0) begin
        cnt_nxt = (in_rx_byte == LEAD_BYTE) ? 4'd1 : 4'd0;
      end else if (cnt_r == LAST_IDX) begin
        cnt_nxt     = 4'd0;
        ctl_nxt.vld = (fb_r[1] == TYPE_TOUCH) &&
                      ((fb_r[2] == CODE_TOUCH) || (fb_r[2] == CODE_UNTOUCH));
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 4'd0;
      ctl_r.vld <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      ctl_r.vld <= ctl_nxt.vld;
    end
    ctl_r.touch <= ctl_nxt.touch;
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= 6; i++) begin
      if (acc && (cnt_r == 4'(i))) begin
        fb_r[i] <= in_rx_byte;
      end
    end
  end

  assign frm_ctl = ctl_r;
  assign raw_x   = $signed({fb_r[4], fb_r[3]});
  assign raw_y   = $signed({fb_r[6], fb_r[5]});

endmodule
`default_nettype wire

@@ hw/rtl/tpd_scale.sv @@
// Q16.16 coordinate scaling: offset add, multiply, truncate and saturate, or raw pass-through in bypass.
`timescale 1ns / 1ps
`default_nettype none
module tpd_scale
  import tpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stg_ctl_t           ctl_in,
  input  wire logic signed [15:0] raw_x,
  input  wire logic signed [15:0] raw_y,
  input  wire logic signed [31:0] gain_x,
  input  wire logic signed [15:0] offset_x,
  input  wire logic signed [31:0] gain_y,
  input  wire logic signed [15:0] offset_y,
  input  wire logic               bypass,
  output stg_ctl_t                ctl_out,
  output logic signed [15:0]      pos_x,
  output logic signed [15:0]      pos_y,
  output logic                    busy
);

  stg_ctl_t           s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic signed [16:0] sum_x_r, sum_y_r, sum_x_nxt, sum_y_nxt;
  logic signed [15:0] rx1_r, ry1_r, rx2_r, ry2_r;
  logic signed [48:0] prod_x_r, prod_y_r, prod_x_nxt, prod_y_nxt;
  logic signed [15:0] px_r, py_r, px_nxt, py_nxt;

  // shift right by 16 rounding toward zero, then clamp to 16 bits
  function automatic logic signed [15:0] fix_q16(input logic signed [48:0] p);
    logic signed [32:0] q;
    logic               adj;
    adj = p[48] & (|p[15:0]);
    q   = $signed(p[48:16]) + $signed({32'd0, adj});
    if (q > 33'sd32767) begin
      fix_q16 = 16'sh7fff;
    end else if (q < -33'sd32768) begin
      fix_q16 = 16'sh8000;
    end else begin
      fix_q16 = q[15:0];
    end
  endfunction

  assign sum_x_nxt  = $signed({raw_x[15], raw_x}) + $signed({offset_x[15], offset_x});
  assign sum_y_nxt  = $signed({raw_y[15], raw_y}) + $signed({offset_y[15], offset_y});
  assign prod_x_nxt = sum_x_r * gain_x;
  assign prod_y_nxt = sum_y_r * gain_y;
  assign px_nxt     = bypass ? rx2_r : fix_q16(prod_x_r);
  assign py_nxt     = bypass ? ry2_r : fix_q16(prod_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.vld <= 1'b0;
      s2_ctl_r.vld <= 1'b0;
      s3_ctl_r.vld <= 1'b0;
    end else begin
      s1_ctl_r.vld <= ctl_in.vld;
      s2_ctl_r.vld <= s1_ctl_r.vld;
      s3_ctl_r.vld <= s2_ctl_r.vld;
    end
    s1_ctl_r.touch <= ctl_in.touch;
    s2_ctl_r.touch <= s1_ctl_r.touch;
    s3_ctl_r.touch <= s2_ctl_r.touch;
    sum_x_r  <= sum_x_nxt;
    sum_y_r  <= sum_y_nxt;
    rx1_r    <= raw_x;
    ry1_r    <= raw_y;
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
    rx2_r    <= rx1_r;
    ry2_r    <= ry1_r;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
  end

  assign ctl_out = s3_ctl_r;
  assign pos_x   = px_r;
  assign pos_y   = py_r;
  assign busy    = s1_ctl_r.vld | s2_ctl_r.vld | s3_ctl_r.vld;

endmodule
`default_nettype wire

@@ hw/rtl/tpd_event.sv @@
// Event generation: touch position store, untouch snap, output register.
`timescale 1ns / 1ps
`default_nettype none
module tpd_event
  import tpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stg_ctl_t           ctl_in,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic [14:0]        snap_distance,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_event_kind,
  output logic signed [15:0]      out_pos_x,
  output logic signed [15:0]      out_pos_y,
  output logic                    out_button,
  output logic                    out_last,
  output logic                    busy
);

  logic signed [15:0] tp_x_r, tp_y_r, tp_x_nxt, tp_y_nxt;
  logic               ov_r, ov_nxt, mot_r, mot_nxt;
  ev_kind_t           kind_r, kind_nxt;
  logic signed [15:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic               btn_r, btn_nxt, last_r, last_nxt;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               snap_x, snap_y;

  assign dx     = $signed({pos_x[15], pos_x}) - $signed({tp_x_r[15], tp_x_r});
  assign dy     = $signed({pos_y[15], pos_y}) - $signed({tp_y_r[15], tp_y_r});
  assign adx    = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady    = dy[16] ? 17'(-dy) : 17'(dy);
  assign snap_x = adx < {2'b00, snap_distance};
  assign snap_y = ady < {2'b00, snap_distance};

  always_comb begin
    tp_x_nxt = tp_x_r;
    tp_y_nxt = tp_y_r;
    ov_nxt   = ov_r;
    mot_nxt  = mot_r;
    kind_nxt = kind_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    btn_nxt  = btn_r;
    last_nxt = last_r;
    if (ov_r && out_ready) begin
      if (mot_r) begin
        mot_nxt  = 1'b0;
        kind_nxt = EV_MOTION;
        ox_nxt   = OFFSCREEN;
        oy_nxt   = OFFSCREEN;
        btn_nxt  = 1'b0;
        last_nxt = 1'b1;
      end else begin
        ov_nxt = 1'b0;
      end
    end
    if (ctl_in.vld) begin
      ov_nxt  = 1'b1;
      btn_nxt = 1'b1;
      if (ctl_in.touch) begin
        tp_x_nxt = pos_x;
        tp_y_nxt = pos_y;
        kind_nxt = EV_DOWN;
        ox_nxt   = pos_x;
        oy_nxt   = pos_y;
        last_nxt = 1'b1;
      end else begin
        kind_nxt = EV_UP;
        ox_nxt   = snap_x ? tp_x_r : pos_x;
        oy_nxt   = snap_y ? tp_y_r : pos_y;
        last_nxt = 1'b0;
        mot_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_x_r <= '0;
      tp_y_r <= '0;
      ov_r   <= 1'b0;
      mot_r  <= 1'b0;
    end else begin
      tp_x_r <= tp_x_nxt;
      tp_y_r <= tp_y_nxt;
      ov_r   <= ov_nxt;
      mot_r  <= mot_nxt;
    end
    kind_r <= kind_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    btn_r  <= btn_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = ov_r;
  assign out_event_kind = kind_r;
  assign out_pos_x      = ox_r;
  assign out_pos_y      = oy_r;
  assign out_button     = btn_r;
  assign out_last       = last_r;
  assign busy           = ov_r | mot_r;

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench for touch_packet_decoder: directed frames, random byte streams, event checking.
`timescale 1ns / 1ps
module tb;
  import tpd_pkg::*;

  localparam int FRAME_LEN     = int'(LAST_IDX) + 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BYTES   = 130;
  localparam int MAX_REPORTS   = 30;

  localparam logic [7:0] TYPE_OTHER = 8'h41;
  localparam logic [7:0] CODE_OTHER = 8'h02;

  typedef enum logic [1:0] {ROW_CFG, ROW_FRAME, ROW_NOISE} row_op_t;

  typedef struct packed {
    ev_kind_t           kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               button;
    logic               last;
  } touch_event_t;

  typedef struct {
    row_op_t            op;
    cfg_reg_t           idx;
    logic [31:0]        data;
    logic [7:0]         ftype;
    logic [7:0]         code;
    logic [15:0]        rx;
    logic [15:0]        ry;
    logic               typed;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_GAIN_X;
  logic [31:0] cfg_data = 32'h0;

  wire logic               in_ready;
  wire logic               out_valid;
  wire logic [1:0]         out_event_kind;
  wire logic signed [15:0] out_pos_x;
  wire logic signed [15:0] out_pos_y;
  wire logic               out_button;
  wire logic               out_last;

  touch_packet_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_button     (out_button),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // calibration copy and decoder state
  logic signed [31:0] cal_gain_x = GAIN_X_RST;
  logic signed [15:0] cal_off_x  = OFFSET_X_RST;
  logic signed [31:0] cal_gain_y = GAIN_Y_RST;
  logic signed [15:0] cal_off_y  = OFFSET_Y_RST;
  logic               cal_raw    = 1'b0;
  logic [14:0]        cal_snap   = SNAP_RST;

  int                 frame_cnt = 0;
  logic [7:0]         frame_buf [FRAME_LEN];
  logic signed [15:0] touch_x = '0;
  logic signed [15:0] touch_y = '0;

  touch_event_t pending_events [$];

  int err_cnt = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int events_checked = 0;
  int downs_seen = 0;
  int ups_seen = 0;
  int settings_used = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  bit stall_req = 1'b0;

  function automatic logic signed [15:0] scale_axis(logic signed [15:0] raw,
                                                    logic signed [15:0] off,
                                                    logic signed [31:0] gain);
    longint sum, prod, q;
    sum  = longint'(raw) + longint'(off);
    prod = sum * longint'(gain);
    // truncate toward zero
    q = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic within_snap(logic signed [15:0] a, logic signed [15:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d < int'(cal_snap);
  endfunction

  function automatic int decode_byte(input logic [7:0] b,
                                     output touch_event_t ev0, output touch_event_t ev1);
    logic signed [15:0] px, py;
    ev0 = '0;
    ev1 = '0;
    if (frame_cnt == 0) begin
      if (b == LEAD_BYTE) begin
        frame_buf[0] = b;
        frame_cnt = 1;
      end
      return 0;
    end
    frame_buf[frame_cnt] = b;
    frame_cnt++;
    if (frame_cnt < FRAME_LEN) return 0;
    frame_cnt = 0;
    if (frame_buf[1] != TYPE_TOUCH) return 0;
    px = {frame_buf[4], frame_buf[3]};
    py = {frame_buf[6], frame_buf[5]};
    if (!cal_raw) begin
      px = scale_axis(px, cal_off_x, cal_gain_x);
      py = scale_axis(py, cal_off_y, cal_gain_y);
    end
    if (frame_buf[2] == CODE_TOUCH) begin
      touch_x = px;
      touch_y = py;
      ev0 = '{EV_DOWN, px, py, 1'b1, 1'b1};
      return 1;
    end
    if (frame_buf[2] == CODE_UNTOUCH) begin
      if (within_snap(px, touch_x)) px = touch_x;
      if (within_snap(py, touch_y)) py = touch_y;
      ev0 = '{EV_UP, px, py, 1'b1, 1'b0};
      ev1 = '{EV_MOTION, OFFSCREEN, OFFSCREEN, 1'b0, 1'b1};
      return 2;
    end
    return 0;
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      if (err_cnt < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  function automatic plan_row_t frm_row(logic [7:0] ftype, logic [7:0] code,
                                        logic [15:0] rx, logic [15:0] ry, logic typed,
                                        logic signed [15:0] tx, logic signed [15:0] ty);
    plan_row_t r;
    r.op = ROW_FRAME;
    r.idx = REG_GAIN_X;
    r.data = '0;
    r.ftype = ftype;
    r.code = code;
    r.rx = rx;
    r.ry = ry;
    r.typed = typed;
    r.tx = tx;
    r.ty = ty;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_t idx, logic [31:0] d);
    plan_row_t r;
    r = frm_row('0, '0, '0, '0, 1'b0, '0, '0);
    r.op = ROW_CFG;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  function automatic plan_row_t noise_row(logic [7:0] b);
    plan_row_t r;
    r = frm_row('0, '0, '0, '0, 1'b0, '0, '0);
    r.op = ROW_NOISE;
    r.data = {24'h0, b};
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input logic signed [15:0] tx, input logic signed [15:0] ty);
    touch_event_t ev0, ev1;
    int n;
    while (in_idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = decode_byte(b, ev0, ev1);
    if (typed && n > 0) begin
      ev0.pos_x = tx;
      ev0.pos_y = ty;
    end
    if (n > 0) pending_events.push_back(ev0);
    if (n > 1) pending_events.push_back(ev1);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] code,
                            input logic [15:0] rx, input logic [15:0] ry, input logic typed,
                            input logic signed [15:0] tx, input logic signed [15:0] ty);
    logic [7:0] fb [FRAME_LEN];
    fb[0] = LEAD_BYTE;
    fb[1] = ftype;
    fb[2] = code;
    fb[3] = rx[7:0];
    fb[4] = rx[15:8];
    fb[5] = ry[7:0];
    fb[6] = ry[15:8];
    for (int k = 7; k < FRAME_LEN; k++) fb[k] = 8'($urandom);
    for (int k = 0; k < FRAME_LEN; k++) send_byte(fb[k], typed && k == FRAME_LEN - 1, tx, ty);
    frames_sent++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_X:   cal_gain_x = d;
      REG_OFFSET_X: cal_off_x = d[15:0];
      REG_GAIN_Y:   cal_gain_y = d;
      REG_OFFSET_Y: cal_off_y = d[15:0];
      REG_BYPASS:   cal_raw = d[0];
      REG_SNAP:     cal_snap = d[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin : result_sink
    touch_event_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $error("unexpected transaction: event_kind %0d with nothing pending",
                   out_event_kind);
          err_cnt++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", int'(want.kind), int'(out_event_kind));
          check_field("pos_x", int'(want.pos_x), int'(out_pos_x));
          check_field("pos_y", int'(want.pos_y), int'(out_pos_y));
          check_field("button", int'(want.button), int'(out_button));
          check_field("last", int'(want.last), int'(out_last));
          events_checked++;
          if (want.kind == EV_DOWN) downs_seen++;
          if (want.kind == EV_UP) ups_seen++;
        end
      end
      if (stall_req) begin
        hold_left = HOLD_CYCLES;
        stall_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(out_idle_on && $urandom_range(99) < 15);
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    logic [31:0] gx, ox, gy, oy;
    logic rm;
    logic [14:0] sd;
    logic [7:0] code;
    logic [15:0] rx, ry, near_x, near_y;
    int pick, phase_end;

    near_x = '0;
    near_y = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: noise, untouch before any touch, a touch landing on 0,0, then ignored frames
    plan.push_back(noise_row(8'h00));
    plan.push_back(noise_row(8'hFF));
    plan.push_back(noise_row(TYPE_TOUCH));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_UNTOUCH, 3680, 510, 1'b1, 0, 0));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_TOUCH, 3670, 500, 1'b1, 0, 0));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_OTHER, 1234, 4321, 1'b0, 0, 0));
    plan.push_back(frm_row(TYPE_OTHER, CODE_TOUCH, 1234, 4321, 1'b0, 0, 0));
    // raw mode, snap off then at max
    plan.push_back(cfg_row(REG_BYPASS, 32'd1));
    plan.push_back(cfg_row(REG_SNAP, 32'd0));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_TOUCH, 16'h8000, 16'h7FFF, 1'b1, -32768, 32767));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_UNTOUCH, 16'h8001, 16'h7FFF, 1'b1, -32767, 32767));
    plan.push_back(cfg_row(REG_SNAP, 32'h7FFF));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_UNTOUCH, 0, 0, 1'b1, 0, 0));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_UNTOUCH, -2, 1, 1'b1, -32768, 32767));
    // saturation at both ends
    plan.push_back(cfg_row(REG_BYPASS, 32'd0));
    plan.push_back(cfg_row(REG_GAIN_X, 32'h7FFF_FFFF));
    plan.push_back(cfg_row(REG_OFFSET_X, 32'd32767));
    plan.push_back(cfg_row(REG_GAIN_Y, 32'h8000_0000));
    plan.push_back(cfg_row(REG_OFFSET_Y, 32'd32767));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_TOUCH, 32767, 32767, 1'b1, 32767, -32768));
    plan.push_back(cfg_row(REG_OFFSET_X, 32'hFFFF_8000));
    plan.push_back(cfg_row(REG_OFFSET_Y, 32'hFFFF_8000));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_TOUCH, 16'h8000, 16'h8000, 1'b1, -32768, 32767));
    // unit gains, snap boundary, truncation toward zero
    plan.push_back(cfg_row(REG_GAIN_X, 32'h0001_0000));
    plan.push_back(cfg_row(REG_OFFSET_X, 32'd0));
    plan.push_back(cfg_row(REG_GAIN_Y, 32'hFFFF_0000));
    plan.push_back(cfg_row(REG_OFFSET_Y, 32'd0));
    plan.push_back(cfg_row(REG_SNAP, 32'd30));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_TOUCH, 100, -7, 1'b1, 100, 7));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_UNTOUCH, 129, -36, 1'b1, 100, 7));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_UNTOUCH, 130, -37, 1'b1, 130, 37));
    plan.push_back(cfg_row(REG_GAIN_X, 32'h0000_8000));
    plan.push_back(frm_row(TYPE_TOUCH, CODE_TOUCH, -3, 5, 1'b1, -1, -5));

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        drain_pipe();
        write_reg(plan[i].idx, plan[i].data);
        settings_used++;
      end else if (plan[i].op == ROW_NOISE) begin
        send_byte(plan[i].data[7:0], 1'b0, '0, '0);
      end else begin
        send_frame(plan[i].ftype, plan[i].code, plan[i].rx, plan[i].ry,
                   plan[i].typed, plan[i].tx, plan[i].ty);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipe();
      gx = $signed($urandom_range(0, 262144)) - 131072;
      gy = $signed($urandom_range(0, 262144)) - 131072;
      ox = $urandom;
      oy = $urandom;
      rm = 1'($urandom_range(0, 1));
      sd = $urandom_range(0, 1) ? 15'($urandom_range(0, 64)) : 15'($urandom_range(0, 32767));
      case (ph)
        0: begin
          gx = GAIN_X_RST;
          ox = 32'(OFFSET_X_RST);
          gy = GAIN_Y_RST;
          oy = 32'(OFFSET_Y_RST);
          rm = 1'b0;
          sd = SNAP_RST;
        end
        1: begin
          rm = 1'b1;
          sd = '0;
        end
        2: begin
          rm = 1'b1;
          sd = 15'h7FFF;
        end
        3: begin
          rm = 1'b0;
          gx = 32'h7FFF_FFFF;
          gy = 32'h8000_0000;
        end
        4: rm = 1'b0;
        default: ;
      endcase
      in_idle_on = (ph != 4);
      out_idle_on = (ph != 4);
      write_reg(REG_GAIN_X, gx);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_GAIN_Y, gy);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_BYPASS, {31'h0, rm});
      write_reg(REG_SNAP, {17'h0, sd});
      settings_used++;
      // long output hold-off while bytes keep coming
      if (ph == 2) stall_req = 1'b1;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          code = $urandom_range(0, 1) ? CODE_TOUCH : CODE_UNTOUCH;
          if ($urandom_range(0, 1)) begin
            rx = 16'($urandom);
            ry = 16'($urandom);
          end else begin
            rx = 16'(near_x + $urandom_range(0, 80) - 40);
            ry = 16'(near_y + $urandom_range(0, 80) - 40);
          end
          send_frame(TYPE_TOUCH, code, rx, ry, 1'b0, '0, '0);
          if (code == CODE_TOUCH) begin
            near_x = rx;
            near_y = ry;
          end
        end else if (pick < 78) begin
          send_frame(TYPE_TOUCH, 8'($urandom), 16'($urandom), 16'($urandom),
                     1'b0, '0, '0);
        end else if (pick < 85) begin
          send_frame(8'($urandom), $urandom_range(0, 1) ? CODE_TOUCH : CODE_UNTOUCH,
                     16'($urandom), 16'($urandom), 1'b0, '0, '0);
        end else if (pick < 97) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0, '0);
        end else begin
          // truncated frame: the bytes that follow complete it
          send_byte(LEAD_BYTE, 1'b0, '0, '0);
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0, '0, '0);
        end
      end
    end

    drain_pipe();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames under %0d register settings; %0d events checked",
             bytes_sent, frames_sent, settings_used, events_checked);
    $display("(%0d button-down, %0d button-up), raw and scaled, saturation, snap 0 and max.",
             downs_seen, ups_seen);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_frame.sv
hw/rtl/tpd_scale.sv
hw/rtl/tpd_event.sv
hw/rtl/touch_packet_decoder.sv
test/tb.sv
